[design/sfsx_pkg.sv]
// Shared constants, types and codes for the serial frame sync and XOR check block.
`timescale 1ns / 1ps

package sfsx_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int DATA_BYTES  = 20;
  localparam int NUM_WORDS   = 10;
  localparam int MEM_DEPTH   = 64;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int WORD_W      = 4;

  localparam logic [7:0] SYNC_START = 8'h53;
  localparam logic [7:0] SYNC_END   = 8'h0A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] KIND_BYTE_ACTUAL   = 8'h00;
  localparam logic [7:0] KIND_BYTE_SETPOINT = 8'h01;

  localparam logic [1:0] KIND_ACTUAL   = 2'd0;
  localparam logic [1:0] KIND_SETPOINT = 2'd1;
  localparam logic [1:0] KIND_OTHER    = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ERR,
    ST_WLO,
    ST_WHI,
    ST_WEMIT
  } chk_state_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic              valid;
    logic [MEM_AW-1:0] base;
  } det_t;

endpackage

[design/sfsx_frame_ctrl.sv]
// Byte memory, frame check sequencer and result register.
`timescale 1ns / 1ps

module sfsx_frame_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  sfsx_pkg::wr_t      wr,
  input  sfsx_pkg::det_t     det,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [1:0]         out_frame_kind,
  output logic [3:0]         out_word_index,
  output logic [15:0]        out_word_value,
  output logic               out_last
);
  import sfsx_pkg::*;

  logic [7:0] mem [MEM_DEPTH];

  chk_state_t        state_r, state_nxt;
  logic [MEM_AW-1:0] base_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              dv_r;
  logic [IDX_W-1:0]  dv_idx_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        ex_r, ox_r, lo_r;
  logic              ok_r;
  logic [1:0]        kind_r;

  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;
  logic              slot_free;
  logic              load_err, load_word;
  logic              ok_final;

  logic              out_valid_r;
  logic              out_status_r;
  logic [1:0]        out_kind_r;
  logic [3:0]        out_index_r;
  logic [15:0]       out_value_r;
  logic              out_last_r;

  // Memory: one write port from the input side, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign ok_final  = ok_r && (rd_data_r == CR_BYTE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    word_nxt  = word_r;
    rd_en     = 1'b0;
    rd_addr   = base_r + MEM_AW'(cnt_r);
    load_err  = 1'b0;
    load_word = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (det.valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
          word_nxt  = '0;
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(FRAME_BYTES - 2)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The carriage return byte arrives here and settles the verdict.
        state_nxt = ok_final ? ST_WLO : ST_ERR;
      end
      ST_ERR: begin
        if (slot_free) begin
          load_err  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WLO: begin
        rd_en     = 1'b1;
        rd_addr   = base_r + {1'b0, word_r, 1'b0};
        state_nxt = ST_WHI;
      end
      ST_WHI: begin
        rd_en     = 1'b1;
        rd_addr   = base_r + {1'b0, word_r, 1'b1};
        state_nxt = ST_WEMIT;
      end
      ST_WEMIT: begin
        if (slot_free) begin
          load_word = 1'b1;
          if (word_r == WORD_W'(NUM_WORDS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            word_nxt  = word_r + 1'b1;
            state_nxt = ST_WLO;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= (state_r == ST_SCAN);
      out_valid_r <= (load_err || load_word) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    word_r   <= word_nxt;
    dv_idx_r <= cnt_r;
    if (state_r == ST_IDLE && det.valid) begin
      base_r <= det.base;
      ex_r   <= '0;
      ox_r   <= '0;
      ok_r   <= 1'b1;
    end else if (dv_r) begin
      if (dv_idx_r < IDX_W'(DATA_BYTES)) begin
        if (dv_idx_r[0]) begin
          ox_r <= ox_r ^ rd_data_r;
        end else begin
          ex_r <= ex_r ^ rd_data_r;
        end
      end
      if (dv_idx_r == IDX_W'(1)) begin
        if (rd_data_r == KIND_BYTE_ACTUAL) begin
          kind_r <= KIND_ACTUAL;
        end else if (rd_data_r == KIND_BYTE_SETPOINT) begin
          kind_r <= KIND_SETPOINT;
        end else begin
          kind_r <= KIND_OTHER;
        end
      end
      // Even and odd sums are complete before their check bytes come back.
      if (dv_idx_r == IDX_W'(DATA_BYTES) && rd_data_r != ex_r) begin
        ok_r <= 1'b0;
      end
      if (dv_idx_r == IDX_W'(DATA_BYTES + 1) && rd_data_r != ox_r) begin
        ok_r <= 1'b0;
      end
    end
    if (state_r == ST_WHI) begin
      lo_r <= rd_data_r;
    end
    if (load_err) begin
      out_status_r <= STATUS_ERR;
      out_kind_r   <= KIND_ACTUAL;
      out_index_r  <= '0;
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (load_word) begin
      out_status_r <= STATUS_OK;
      out_kind_r   <= kind_r;
      out_index_r  <= word_r;
      out_value_r  <= {rd_data_r, lo_r};
      out_last_r   <= (word_r == WORD_W'(NUM_WORDS - 1));
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_frame_kind = out_kind_r;
  assign out_word_index = out_index_r;
  assign out_word_value = out_value_r;
  assign out_last       = out_last_r;

endmodule

[design/serial_frame_sync_xor_check.sv]
// Top level of the serial frame finder with XOR check.
`timescale 1ns / 1ps

//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, in_rx_byte             | in
//  result  | out_valid, out_ready, out_status,          | out
//          | out_frame_kind, out_word_index,            |
//          | out_word_value, out_last                   |
//
// A byte is taken every cycle while in_ready is high and is written into a 64-entry
// byte ring at once. A found frame takes 23 memory reads for the XOR and carriage
// return check, a verdict state, then a low read, a high read and an emit state per
// word on the single read port. A bad frame gives its one beat at the end. Output
// stalls hold the checker; input beats stop only when 23 bytes of the next frame
// have come in while the checker still runs. Reset clears the fill count, the ring
// pointer and the checker; the ring itself is not cleared and needs no sweep.

module serial_frame_sync_xor_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [1:0]  out_frame_kind,
  output logic [3:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic        out_last
);
  import sfsx_pkg::*;

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);

  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [MEM_AW-1:0]      wr_ptr_r;
  logic [FRAME_BYTES-2:0] s_hist_r;
  logic                   acc;
  logic                   busy;
  wr_t                    wr;
  det_t                   det;

  assign in_ready = !(busy && fill_r == FILL_W'(FRAME_BYTES - 1));
  assign acc      = in_valid && in_ready;

  // The start flag 23 beats back marks the oldest byte of a full window.
  assign det.valid = acc && (fill_r >= FILL_W'(FRAME_BYTES - 1)) &&
                     s_hist_r[FRAME_BYTES-2] && (in_rx_byte == SYNC_END);
  assign det.base  = wr_ptr_r - MEM_AW'(FRAME_BYTES - 1);

  assign wr.en   = acc;
  assign wr.addr = wr_ptr_r;
  assign wr.data = in_rx_byte;

  always_comb begin
    fill_nxt = fill_r;
    if (det.valid) begin
      fill_nxt = '0;
    end else if (acc && fill_r < FILL_W'(FRAME_BYTES)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      wr_ptr_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (acc) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_hist_r <= {s_hist_r[FRAME_BYTES-3:0], (in_rx_byte == SYNC_START)};
    end
  end

  sfsx_frame_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (wr),
    .det            (det),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_frame_kind (out_frame_kind),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_no_full_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> fill_r != FILL_W'(FRAME_BYTES))
    else $error("window filled up while the checker still holds a frame");

  a_detect_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    det.valid |=> busy)
    else $error("found frame did not start the checker");

  a_error_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_ERR) |->
      (out_last && out_word_value == 16'd0 && out_word_index == 4'd0))
    else $error("error beat carries data or is not marked last");
`endif

endmodule
